// File: design/iprc_pkg.sv
// ----------------------------------------------------------------------------
// iprc_pkg: shared types and constants
// Codes, table entry layout and prefix check helper for the IPv4 prefix
// range classifier.
// ----------------------------------------------------------------------------
package iprc_pkg;

	// operation codes of an input word
	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
	localparam logic [1:0] STATUS_HOST_SET = 2'd2;

	localparam logic [31:0] FULL_MASK  = 32'hffff_ffff;
	localparam logic [5:0]  MAX_PREFIX = 6'd32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] mask;
		logic [7:0]  block;
		logic [15:0] signature;
	} entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] mask;
	} prefix_chk_t;

	// Check a prefix: absent length counts as full, long lengths and host
	// bits outside the mask are flagged.
	function automatic prefix_chk_t check_prefix(logic [31:0] addr, logic [5:0] len);
		logic [5:0]  len_eff;
		prefix_chk_t res;
		len_eff = (len == 6'd0) ? MAX_PREFIX : len;
		res.mask = ~(FULL_MASK >> len_eff);
		if (len_eff > MAX_PREFIX) begin
			res.status = STATUS_BAD_LEN;
		end else if ((addr & ~res.mask) != 32'd0) begin
			res.status = STATUS_HOST_SET;
		end else begin
			res.status = STATUS_OK;
		end
		return res;
	endfunction

endpackage

// File: design/iprc_table.sv
// ----------------------------------------------------------------------------
// iprc_table: prefix entry store
// Single write port, single registered read port, valid bits in flops.
// ----------------------------------------------------------------------------
module iprc_table #(
	parameter int TABLE_ENTRIES = 64,
	parameter int IDX_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_idx,
	input  iprc_pkg::entry_t     wr_entry,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_idx,
	output iprc_pkg::entry_t     rd_entry,
	output logic                 rd_valid
);

	iprc_pkg::entry_t           mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0]   valid_q;

	// write entry, read one entry per cycle while rd_en is high
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry <= mem_q[rd_idx];
		end
	end

	// mark written slots, register hit qualifier of the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			rd_valid <= rd_en & valid_q[rd_idx];
		end
	end

endmodule

// File: design/iprc_match.sv
// ----------------------------------------------------------------------------
// iprc_match: shared compare unit
// Masks source and destination with one entry and compares to its address.
// ----------------------------------------------------------------------------
module iprc_match (
	input  logic              entry_valid,
	input  iprc_pkg::entry_t  entry,
	input  logic [31:0]       src,
	input  logic [31:0]       dst,
	output logic              hit
);

	// hit when the entry is valid and either masked address equals the entry address
	always_comb begin
		hit = entry_valid &&
		      (((src & entry.mask) == entry.address) ||
		       ((dst & entry.mask) == entry.address));
	end

endmodule

// File: design/ip_prefix_range_classifier_top.sv
// ----------------------------------------------------------------------------
// ip_prefix_range_classifier_top: IPv4 prefix range classifier
// Prefix table with load checking and a sequential classify scan.
// ----------------------------------------------------------------------------
// A load word gives its single result on the next cycle; busy stays low, so
// loads can follow back to back. A classify word holds busy high until the
// scan is flushed: the table has one read port and the scan reads one entry
// per cycle through a single compare unit. Matches come out in slot order,
// one per cycle at most, each held until the next match or the flush and put
// out in the cycle after it; the last result (is_last high) comes on the
// final busy cycle's edge. The receiver cannot stall, so every strobe must be
// captured.
// ----------------------------------------------------------------------------
module ip_prefix_range_classifier_top #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [5:0]  entry_index,
	input  logic [31:0] prefix_address,
	input  logic [5:0]  prefix_length,
	input  logic [7:0]  block_id,
	input  logic [15:0] signature_id,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	output logic        strobe,
	output logic [1:0]  status,
	output logic        match_valid,
	output logic [7:0]  hint_block,
	output logic [15:0] hint_signature,
	output logic        is_last
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [6:0] ENTRIES_W7 = 7'(TABLE_ENTRIES);

	iprc_pkg::state_t      state_q, state_d;
	logic [IDX_W-1:0]      scan_idx_q;
	logic                  issue_q;
	logic                  last_s1;
	logic [31:0]           src_q, dst_q;
	logic                  pend_q;
	logic [7:0]            pend_blk_q;
	logic [15:0]           pend_sig_q;

	logic                  accept, acc_load, acc_class;
	iprc_pkg::prefix_chk_t chk;
	logic                  wr_en;
	iprc_pkg::entry_t      wr_entry;
	iprc_pkg::entry_t      rd_entry;
	logic                  rd_valid;
	logic                  hit;

	logic                  out_stb_d, out_mv_d, out_last_d;
	logic [1:0]            out_status_d;
	logic [7:0]            out_blk_d;
	logic [15:0]           out_sig_d;

	assign busy      = (state_q != iprc_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign acc_load  = accept && (operation == iprc_pkg::OP_LOAD);
	assign acc_class = accept && (operation == iprc_pkg::OP_CLASSIFY);

	// check prefix and build entry for a load
	always_comb begin
		chk                = iprc_pkg::check_prefix(prefix_address, prefix_length);
		wr_en              = acc_load && (chk.status == iprc_pkg::STATUS_OK) &&
		                     ({1'b0, entry_index} < ENTRIES_W7);
		wr_entry.address   = prefix_address;
		wr_entry.mask      = chk.mask;
		wr_entry.block     = block_id;
		wr_entry.signature = signature_id;
	end

	iprc_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IDX_W         (IDX_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_idx   (entry_index[IDX_W-1:0]),
		.wr_entry (wr_entry),
		.rd_en    (issue_q),
		.rd_idx   (scan_idx_q),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid)
	);

	iprc_match u_match (
		.entry_valid (rd_valid),
		.entry       (rd_entry),
		.src         (src_q),
		.dst         (dst_q),
		.hit         (hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iprc_pkg::ST_IDLE: begin
				if (acc_class) begin
					state_d = iprc_pkg::ST_SCAN;
				end
			end
			iprc_pkg::ST_SCAN: begin
				if (last_s1) begin
					state_d = iprc_pkg::ST_FLUSH;
				end
			end
			iprc_pkg::ST_FLUSH: begin
				state_d = iprc_pkg::ST_IDLE;
			end
			default: begin
				state_d = iprc_pkg::ST_IDLE;
			end
		endcase
	end

	// result word for this cycle
	always_comb begin
		out_stb_d    = 1'b0;
		out_status_d = iprc_pkg::STATUS_OK;
		out_mv_d     = 1'b0;
		out_blk_d    = 8'd0;
		out_sig_d    = 16'd0;
		out_last_d   = 1'b0;
		unique case (state_q)
			iprc_pkg::ST_IDLE: begin
				if (acc_load) begin
					out_stb_d    = 1'b1;
					out_status_d = chk.status;
					out_last_d   = 1'b1;
				end
			end
			iprc_pkg::ST_SCAN: begin
				// a new hit releases the held one, which is then not last
				if (hit && pend_q) begin
					out_stb_d = 1'b1;
					out_mv_d  = 1'b1;
					out_blk_d = pend_blk_q;
					out_sig_d = pend_sig_q;
				end
			end
			iprc_pkg::ST_FLUSH: begin
				out_stb_d  = 1'b1;
				out_last_d = 1'b1;
				if (pend_q) begin
					out_mv_d  = 1'b1;
					out_blk_d = pend_blk_q;
					out_sig_d = pend_sig_q;
				end
			end
			default: begin
				out_stb_d = 1'b0;
			end
		endcase
	end

	// sequencer and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= iprc_pkg::ST_IDLE;
			scan_idx_q <= '0;
			issue_q    <= 1'b0;
			last_s1    <= 1'b0;
			pend_q     <= 1'b0;
			strobe     <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= out_stb_d;
			last_s1 <= issue_q && (scan_idx_q == LAST_IDX);
			if (acc_class) begin
				scan_idx_q <= '0;
				issue_q    <= 1'b1;
				pend_q     <= 1'b0;
			end else if (issue_q) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_idx_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end
			end
			if (hit) begin
				pend_q <= 1'b1;
			end
		end
	end

	// hold flow addresses, pending hint and result payload
	always_ff @(posedge clk) begin
		if (acc_class) begin
			src_q <= source_address;
			dst_q <= dest_address;
		end
		if (hit) begin
			pend_blk_q <= rd_entry.block;
			pend_sig_q <= rd_entry.signature;
		end
		status         <= out_status_d;
		match_valid    <= out_mv_d;
		hint_block     <= out_blk_d;
		hint_signature <= out_sig_d;
		is_last        <= out_last_d;
	end

endmodule
